// ----- rtl/fcc_pkg.sv -----
// Package for the footprint collision checker.
// Grid geometry, fixed-point widths and the controller/datapath interface types.
// No dependencies.
`default_nettype none
package fcc_pkg;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int MAX_ROWS = 1 << ROW_W;
    localparam int MAX_COLS = 1 << COL_W;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LOC_W    = 18;   // footprint loop coordinate, with headroom for one step
    localparam int PROD_W   = LOC_W + 16;
    localparam int SUM_W    = 37;
    localparam int FRAC_W   = 22;
    localparam int CIDX_W   = SUM_W - FRAC_W;
    localparam int MIN_STEP = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

    typedef struct packed {
        logic wr;    // store a map cell
        logic load;  // capture pose, restart footprint walk
        logic mul;   // form the rotation products
        logic sum;   // add products and pose
        logic adv;   // step to the next footprint sample
    } t_cmd;

    typedef struct packed {
        logic empty; // footprint has no samples
        logic off;   // current sample is off the map
        logic hit;   // read cell is above threshold
        logic last;  // current sample is the final one
    } t_status;
endpackage
`default_nettype wire

// ----- rtl/footprint_collision_check.sv -----
// Footprint collision check against an occupancy grid held in one map RAM.
// A write's acknowledge appears on the cycle after the transfer.
// A query checks for an empty footprint, then steps each sample through multiply, sum, address and RAM compare.
// The query ends early on the first sample off the map or on an obstacle.
// Synchronous active-low reset restores the register defaults; the map is not cleared.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`default_nettype none
module footprint_collision_check (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           i_cfg_we,
    input  wire [fcc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire [fcc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire                           i_req_type,
    input  wire [9:0]                     i_cell_row,
    input  wire [9:0]                     i_cell_col,
    input  wire [7:0]                     i_pixel_value,
    input  wire signed [20:0]             i_pose_x,
    input  wire signed [20:0]             i_pose_y,
    input  wire signed [15:0]             i_cos_heading,
    input  wire signed [15:0]             i_sin_heading,
    output logic                          o_valid,
    output logic                          o_collision,
    output logic                          o_was_query
);
    fcc_pkg::t_cmd    cmd;
    fcc_pkg::t_status status;

    fcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req_type),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_collision (o_collision),
        .o_was_query (o_was_query)
    );

    fcc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_pixel_value (i_pixel_value),
        .i_pose_x      (i_pose_x),
        .i_pose_y      (i_pose_y),
        .i_cos_heading (i_cos_heading),
        .i_sin_heading (i_sin_heading),
        .i_cmd         (cmd),
        .o_status      (status)
    );
endmodule
`default_nettype wire

// ----- rtl/fcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/fcc_datapath.sv -----
// Datapath: configuration registers, footprint walk, rotation arithmetic and map RAM.
// Depends on fcc_pkg and fcc_ram.
`default_nettype none
module fcc_datapath (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [fcc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire [fcc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire [9:0]                     i_cell_row,
    input  wire [9:0]                     i_cell_col,
    input  wire [7:0]                     i_pixel_value,
    input  wire signed [20:0]             i_pose_x,
    input  wire signed [20:0]             i_pose_y,
    input  wire signed [15:0]             i_cos_heading,
    input  wire signed [15:0]             i_sin_heading,
    input  fcc_pkg::t_cmd                 i_cmd,
    output fcc_pkg::t_status              o_status
);
    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [12:0] r_step;
    logic [7:0]  r_thresh;
    logic [10:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x  <= -16'sd512;
            r_max_x  <= 16'sd512;
            r_min_y  <= -16'sd256;
            r_max_y  <= 16'sd256;
            r_step   <= 13'd256;
            r_thresh <= 8'd127;
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fcc_pkg::REG_MIN_X:  r_min_x  <= i_cfg_wdata;
                fcc_pkg::REG_MAX_X:  r_max_x  <= i_cfg_wdata;
                fcc_pkg::REG_MIN_Y:  r_min_y  <= i_cfg_wdata;
                fcc_pkg::REG_MAX_Y:  r_max_y  <= i_cfg_wdata;
                fcc_pkg::REG_STEP:   r_step   <= i_cfg_wdata[12:0];
                fcc_pkg::REG_THRESH: r_thresh <= i_cfg_wdata[7:0];
                fcc_pkg::REG_WIDTH:  r_width  <= i_cfg_wdata[10:0];
                fcc_pkg::REG_HEIGHT: r_height <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    logic [12:0] step_eff;
    logic [10:0] w_eff, h_eff;
    assign step_eff = (r_step < 13'(fcc_pkg::MIN_STEP)) ? 13'(fcc_pkg::MIN_STEP) : r_step;
    assign w_eff = (r_width  > 11'(fcc_pkg::MAX_COLS)) ? 11'(fcc_pkg::MAX_COLS) : r_width;
    assign h_eff = (r_height > 11'(fcc_pkg::MAX_ROWS)) ? 11'(fcc_pkg::MAX_ROWS) : r_height;

    logic signed [20:0] r_px, r_py;
    logic signed [15:0] r_cs, r_sn;
    logic signed [fcc_pkg::LOC_W-1:0] r_lx, r_ly;
    logic signed [fcc_pkg::LOC_W-1:0] n_lx, n_ly, step_s;
    logic signed [fcc_pkg::PROD_W-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [fcc_pkg::SUM_W-1:0] r_wx, r_wy;

    assign step_s = signed'({{(fcc_pkg::LOC_W-13){1'b0}}, step_eff});
    assign n_lx = r_lx + step_s;
    assign n_ly = r_ly + step_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pose_x;
            r_py <= i_pose_y;
            r_cs <= i_cos_heading;
            r_sn <= i_sin_heading;
            r_lx <= fcc_pkg::LOC_W'(r_min_x);
            r_ly <= fcc_pkg::LOC_W'(r_min_y);
        end else if (i_cmd.adv) begin
            // The inner loop runs over y; x steps when y wraps.
            if (n_ly >= fcc_pkg::LOC_W'(r_max_y)) begin
                r_ly <= fcc_pkg::LOC_W'(r_min_y);
                r_lx <= n_lx;
            end else begin
                r_ly <= n_ly;
            end
        end
        if (i_cmd.mul) begin
            r_xc <= r_lx * r_cs;
            r_ys <= r_ly * r_sn;
            r_xs <= r_lx * r_sn;
            r_yc <= r_ly * r_cs;
        end
        if (i_cmd.sum) begin
            r_wx <= fcc_pkg::SUM_W'(r_xc) - fcc_pkg::SUM_W'(r_ys)
                  + signed'({{2{r_px[20]}}, r_px, 14'd0});
            r_wy <= fcc_pkg::SUM_W'(r_xs) + fcc_pkg::SUM_W'(r_yc)
                  + signed'({{2{r_py[20]}}, r_py, 14'd0});
        end
    end

    // The arithmetic shift is the exact floor of the Q.22 value.
    logic signed [fcc_pkg::CIDX_W-1:0] fx, fy;
    logic signed [fcc_pkg::CIDX_W-1:0] w_s, h_s;
    logic [10:0] row_full;
    logic [fcc_pkg::ADDR_W-1:0] raddr;
    logic [7:0] rdata;

    assign fx  = r_wx[fcc_pkg::SUM_W-1:fcc_pkg::FRAC_W];
    assign fy  = r_wy[fcc_pkg::SUM_W-1:fcc_pkg::FRAC_W];
    assign w_s = signed'({{(fcc_pkg::CIDX_W-11){1'b0}}, w_eff});
    assign h_s = signed'({{(fcc_pkg::CIDX_W-11){1'b0}}, h_eff});
    assign row_full = h_eff - 11'd1 - fy[10:0];
    assign raddr = {row_full[fcc_pkg::ROW_W-1:0], fx[fcc_pkg::COL_W-1:0]};

    assign o_status.off   = (fx < 0) || (fx >= w_s) || (fy < 0) || (fy >= h_s);
    assign o_status.hit   = rdata > r_thresh;
    assign o_status.empty = (r_min_x >= r_max_x) || (r_min_y >= r_max_y);
    assign o_status.last  = (n_ly >= fcc_pkg::LOC_W'(r_max_y))
                         && (n_lx >= fcc_pkg::LOC_W'(r_max_x));

    fcc_ram #(
        .WIDTH(fcc_pkg::CELL_W),
        .DEPTH(fcc_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr ({i_cell_row, i_cell_col}),
        .i_wdata (~i_pixel_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );
endmodule
`default_nettype wire

// ----- rtl/fcc_ctrl.sv -----
// Controller: sequences map writes and the per-sample steps of a footprint query.
// Depends on fcc_pkg.
`default_nettype none
module fcc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire               i_req_type,
    input  fcc_pkg::t_status  i_status,
    output fcc_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_valid,
    output logic              o_collision,
    output logic              o_was_query
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MUL, S_SUM, S_ADDR, S_CMP
    } t_state;

    t_state r_state;
    logic accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    always_comb begin
        o_cmd      = '0;
        o_cmd.wr   = accept && !i_req_type;
        o_cmd.load = accept && i_req_type;
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.sum  = (r_state == S_SUM);
        o_cmd.adv  = (r_state == S_CMP) && !i_status.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            o_collision <= 1'b0;
            o_was_query <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && !i_req_type) begin
                        o_valid     <= 1'b1;
                        o_collision <= 1'b0;
                        o_was_query <= 1'b0;
                    end else if (accept) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_status.empty) begin
                        o_valid     <= 1'b1;
                        o_collision <= 1'b0;
                        o_was_query <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_ADDR;
                S_ADDR: begin
                    if (i_status.off) begin
                        o_valid     <= 1'b1;
                        o_collision <= 1'b1;
                        o_was_query <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (i_status.hit || i_status.last) begin
                        o_valid     <= 1'b1;
                        o_collision <= i_status.hit;
                        o_was_query <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- test/footprint_collision_check_test.sv -----
// Self-checking testbench for footprint_collision_check: map writes, collision queries and
// register settings, predicted by an in-bench model of the occupancy grid and footprint walk.
// Depends on fcc_pkg and the footprint_collision_check RTL.
`default_nettype none
module footprint_collision_check_test;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int FILL_SIZE   = 12;   // written corner blocks are FILL_SIZE x FILL_SIZE

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [fcc_pkg::CFG_IDX_W-1:0] i_cfg_addr;
    logic [fcc_pkg::CFG_W-1:0]     i_cfg_wdata;
    logic        i_req_type;
    logic [9:0]  i_cell_row;
    logic [9:0]  i_cell_col;
    logic [7:0]  i_pixel_value;
    logic signed [20:0] i_pose_x;
    logic signed [20:0] i_pose_y;
    logic signed [15:0] i_cos_heading;
    logic signed [15:0] i_sin_heading;
    logic        o_valid;
    logic        o_collision;
    logic        o_was_query;

    footprint_collision_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_req_type(i_req_type), .i_cell_row(i_cell_row), .i_cell_col(i_cell_col),
        .i_pixel_value(i_pixel_value), .i_pose_x(i_pose_x), .i_pose_y(i_pose_y),
        .i_cos_heading(i_cos_heading), .i_sin_heading(i_sin_heading),
        .o_valid(o_valid), .o_collision(o_collision), .o_was_query(o_was_query)
    );

    typedef struct {
        bit collision;
        bit was_query;
    } t_answer;

    t_answer answers_due[$];

    // Grid shadow and register shadow.
    bit [7:0] grid [fcc_pkg::MAP_DEPTH];
    bit       grid_written [fcc_pkg::MAP_DEPTH];
    int       fp_min_x, fp_max_x, fp_min_y, fp_max_y;
    int       fp_step, occ_thresh, grid_w, grid_h;

    int cycles = 0;
    int mismatches;
    int writes_sent, queries_sent, hits_seen, results_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("footprint_collision_check regression: fail");
            $finish;
        end
    end

    // Results are stable around the falling edge; compare them there.
    always @(negedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                $error("unexpected result: collision=%0d was_query=%0d",
                       o_collision, o_was_query);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                if (o_collision !== want.collision) begin
                    $error("collision: expected %0d, actual %0d", want.collision, o_collision);
                    mismatches++;
                end
                if (o_was_query !== want.was_query) begin
                    $error("was_query: expected %0d, actual %0d", want.was_query, o_was_query);
                    mismatches++;
                end
            end
        end
    end

    // Walks the footprint in the block's order. Sets touches_blank when a sample
    // on the map reads a cell that was never written before the walk stops.
    function automatic bit footprint_collides(longint px, longint py, longint cs, longint sn,
                                              output bit touches_blank);
        longint stp, w, h, lx, ly, wx, wy, c, r;
        touches_blank = 0;
        stp = (fp_step < fcc_pkg::MIN_STEP) ? fcc_pkg::MIN_STEP : fp_step;
        w = (grid_w > fcc_pkg::MAX_COLS) ? fcc_pkg::MAX_COLS : grid_w;
        h = (grid_h > fcc_pkg::MAX_ROWS) ? fcc_pkg::MAX_ROWS : grid_h;
        for (lx = fp_min_x; lx < fp_max_x; lx += stp) begin
            for (ly = fp_min_y; ly < fp_max_y; ly += stp) begin
                wx = lx * cs - ly * sn + (px <<< 14);
                wy = lx * sn + ly * cs + (py <<< 14);
                c = wx >>> fcc_pkg::FRAC_W;
                r = h - 1 - (wy >>> fcc_pkg::FRAC_W);
                if (r < 0 || c < 0 || r > h - 1 || c > w - 1)
                    return 1;
                if (!grid_written[r * fcc_pkg::MAX_COLS + c]) begin
                    touches_blank = 1;
                    return 0;
                end
                if (grid[r * fcc_pkg::MAX_COLS + c] > occ_thresh)
                    return 1;
            end
        end
        return 0;
    endfunction

    task automatic idle_start();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one item, waits for its transfer and records the answer it must produce.
    task automatic send_item(bit rt, bit [9:0] row, bit [9:0] col, bit [7:0] pix,
                             bit signed [20:0] px, bit signed [20:0] py,
                             bit signed [15:0] cs, bit signed [15:0] sn, int gap);
        t_answer a;
        bit blank, ready;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= rt;
        i_cell_row    <= row;
        i_cell_col    <= col;
        i_pixel_value <= pix;
        i_pose_x      <= px;
        i_pose_y      <= py;
        i_cos_heading <= cs;
        i_sin_heading <= sn;
        do begin
            @(negedge i_clk);
            ready = !busy;
            @(posedge i_clk);
        end while (!ready);
        a.was_query = rt;
        if (rt) begin
            a.collision = footprint_collides(px, py, cs, sn, blank);
            queries_sent++;
            hits_seen += a.collision;
        end else begin
            a.collision = 0;
            grid[{row, col}] = 8'd255 - pix;
            grid_written[{row, col}] = 1;
            writes_sent++;
        end
        answers_due = {answers_due, a};
    endtask

    function automatic int random_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_write(bit [9:0] row, bit [9:0] col, bit [7:0] pix, int gap);
        send_item(1'b0, row, col, pix, 21'($urandom), 21'($urandom),
                  16'($urandom), 16'($urandom), gap);
    endtask

    // Builds a pose that never reads an unwritten cell; falls back to a pose far
    // off the map, which collides on its first sample without a read.
    task automatic send_query(int gap);
        bit signed [20:0] px, py;
        bit signed [15:0] cs, sn;
        bit blank;
        int tries, c, r, wlim, hlim, k;
        for (tries = 0; tries < 30; tries++) begin
            wlim = (grid_w > fcc_pkg::MAX_COLS) ? fcc_pkg::MAX_COLS : grid_w;
            hlim = (grid_h > fcc_pkg::MAX_ROWS) ? fcc_pkg::MAX_ROWS : grid_h;
            k = $urandom_range(0, 9);
            if (k == 0 || wlim == 0 || hlim == 0) begin
                px = 21'($urandom);
                py = 21'($urandom);
            end else begin
                c = $urandom_range(0, ((wlim < FILL_SIZE) ? wlim : FILL_SIZE) - 1);
                r = $urandom_range(0, ((hlim < FILL_SIZE) ? hlim : FILL_SIZE) - 1);
                if ($urandom_range(0, 1) && hlim > FILL_SIZE)
                    r = hlim - 1 - r;   // row near the top of the used grid
                px = 21'((c <<< 8) + $urandom_range(0, 255));
                py = 21'(((hlim - 1 - r) <<< 8) + $urandom_range(0, 255));
            end
            case ($urandom_range(0, 5))
                0: begin cs = 16'sd16384;  sn = 16'sd0;      end
                1: begin cs = 16'sd0;      sn = 16'sd16384;  end
                2: begin cs = -16'sd16384; sn = 16'sd0;      end
                3: begin cs = 16'sd11585;  sn = -16'sd11585; end
                4: begin cs = 16'($urandom_range(0, 32768) - 16384);
                         sn = 16'($urandom_range(0, 32768) - 16384); end
                default: begin cs = 16'($urandom); sn = 16'($urandom); end
            endcase
            void'(footprint_collides(px, py, cs, sn, blank));
            if (!blank) break;
        end
        if (blank) begin
            px = -21'sd1048576;
            py = 21'($urandom);
        end
        send_item(1'b1, 10'($urandom), 10'($urandom), 8'($urandom), px, py, cs, sn, gap);
    endtask

    task automatic wait_drained();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [fcc_pkg::CFG_IDX_W-1:0] idx, int value);
        idle_start();
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value[15:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            fcc_pkg::REG_MIN_X:  fp_min_x   = $signed(value[15:0]);
            fcc_pkg::REG_MAX_X:  fp_max_x   = $signed(value[15:0]);
            fcc_pkg::REG_MIN_Y:  fp_min_y   = $signed(value[15:0]);
            fcc_pkg::REG_MAX_Y:  fp_max_y   = $signed(value[15:0]);
            fcc_pkg::REG_STEP:   fp_step    = value[12:0];
            fcc_pkg::REG_THRESH: occ_thresh = value[7:0];
            fcc_pkg::REG_WIDTH:  grid_w     = value[10:0];
            fcc_pkg::REG_HEIGHT: grid_h     = value[10:0];
            default: ;
        endcase
    endtask

    task automatic set_footprint(int mnx, int mxx, int mny, int mxy, int stp);
        write_reg(fcc_pkg::REG_MIN_X, mnx);
        write_reg(fcc_pkg::REG_MAX_X, mxx);
        write_reg(fcc_pkg::REG_MIN_Y, mny);
        write_reg(fcc_pkg::REG_MAX_Y, mxy);
        write_reg(fcc_pkg::REG_STEP, stp);
    endtask

    // Fills the bottom-left and top-left corner blocks of the grid.
    task automatic test_fill_grid();
        int r, c;
        for (r = 0; r < FILL_SIZE; r++)
            for (c = 0; c < FILL_SIZE; c++) begin
                send_write(10'(r), 10'(c), 8'($urandom), random_gap());
                send_write(10'(fcc_pkg::MAX_ROWS - 1 - r), 10'(c), 8'($urandom), 0);
            end
    endtask

    // Queries under the reset settings, headings at the axes and beyond unit range.
    task automatic test_reset_defaults();
        send_write(10'd1016, 10'd8, 8'd0, 0);     // occupancy 255
        send_write(10'd1016, 10'd9, 8'd255, 0);   // occupancy 0
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd2304, 21'sd1792, 16'sd16384, 16'sd0, 0);
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd2304, 21'sd1792, 16'sd0, 16'sd16384, 1);
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd2304, 21'sd1792, -16'sd16384, 16'sd0, 0);
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd1024, 21'sd1024, 16'sd32767, -16'sd32768, 0);
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd1048575, 21'sd0, 16'sd16384, 16'sd0, 2);
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd0, -21'sd1048576, 16'sd16384, 16'sd0, 0);
        send_item(1'b1, 10'd0, 10'd0, 8'd0, 21'sd1024, 21'sd1048575, 16'sd16384, 16'sd0, 0);
        send_write(10'd1023, 10'd1023, 8'd128, 0);
        send_write(10'd0, 10'd0, 8'd127, 0);
        repeat (6) send_query(random_gap());
    endtask

    // Extreme and special register settings, each followed by a few queries.
    task automatic test_register_extremes();
        write_reg(fcc_pkg::REG_THRESH, 0);
        repeat (4) send_query(random_gap());
        write_reg(fcc_pkg::REG_THRESH, 255);
        repeat (4) send_query(random_gap());
        write_reg(fcc_pkg::REG_THRESH, 127);
        set_footprint(-32768, 32767, -32768, 32767, 4096);
        repeat (3) send_query(random_gap());
        set_footprint(32767, -32768, -256, 256, 256);          // empty in x
        repeat (2) send_query(0);
        set_footprint(-256, 256, 100, 100, 256);               // empty in y
        repeat (2) send_query(0);
        set_footprint(0, 64, 0, 64, 0);                        // step clamps up
        repeat (3) send_query(random_gap());
        set_footprint(-128, 128, -128, 128, 16);
        repeat (3) send_query(random_gap());
        set_footprint(-512, 512, -256, 256, 8191);
        repeat (2) send_query(random_gap());
        write_reg(fcc_pkg::REG_WIDTH, 2047);                   // saturates
        write_reg(fcc_pkg::REG_HEIGHT, 2047);
        repeat (3) send_query(random_gap());
        write_reg(fcc_pkg::REG_WIDTH, 0);                      // every sample off the map
        repeat (2) send_query(0);
        write_reg(fcc_pkg::REG_WIDTH, 1);
        write_reg(fcc_pkg::REG_HEIGHT, 0);
        repeat (2) send_query(0);
        write_reg(fcc_pkg::REG_HEIGHT, 1);
        repeat (3) send_query(random_gap());
        write_reg(fcc_pkg::REG_WIDTH, FILL_SIZE);
        write_reg(fcc_pkg::REG_HEIGHT, FILL_SIZE);
        repeat (4) send_query(random_gap());
        write_reg(fcc_pkg::REG_WIDTH, 1024);
        write_reg(fcc_pkg::REG_HEIGHT, 1024);
    endtask

    // Random phases: a random setting, then a mix of queries and writes.
    task automatic test_random_traffic();
        int phase, n, stp, mnx, mny;
        for (phase = 0; phase < 3; phase++) begin
            stp = $urandom_range(16, 4096);
            mnx = $urandom_range(0, 4096) - 2048;
            mny = $urandom_range(0, 4096) - 2048;
            set_footprint(mnx, mnx + $urandom_range(0, stp * 8),
                          mny, mny + $urandom_range(0, stp * 8), stp);
            write_reg(fcc_pkg::REG_THRESH, $urandom_range(0, 255));
            write_reg(fcc_pkg::REG_WIDTH,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : 1024);
            write_reg(fcc_pkg::REG_HEIGHT, ($urandom_range(0, 3) == 0) ? FILL_SIZE : 1024);
            for (n = 0; n < 50; n++) begin
                if (n == 25 && phase == 1) begin
                    idle_start();
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 70)
                    send_query(random_gap());
                else if ($urandom_range(0, 1))
                    send_write(10'($urandom_range(0, FILL_SIZE - 1)),
                               10'($urandom_range(0, FILL_SIZE - 1)),
                               8'($urandom), random_gap());
                else
                    send_write(10'($urandom), 10'($urandom), 8'($urandom), random_gap());
            end
        end
    endtask

    initial begin
        mismatches = 0;
        writes_sent = 0; queries_sent = 0; hits_seen = 0; results_seen = 0;
        fp_min_x = -512; fp_max_x = 512; fp_min_y = -256; fp_max_y = 256;
        fp_step = 256; occ_thresh = 127; grid_w = 1024; grid_h = 1024;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_req_type = 1'b0;
        i_cell_row = '0;
        i_cell_col = '0;
        i_pixel_value = '0;
        i_pose_x = '0;
        i_pose_y = '0;
        i_cos_heading = '0;
        i_sin_heading = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_grid();
        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        idle_start();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d map writes and %0d footprint queries (%0d colliding), %0d results",
                 writes_sent, queries_sent, hits_seen, results_seen);
        $display("Register settings included empty footprints, step clamping and map sizes 0 to 2047.");
        if (mismatches == 0 && answers_due.size() == 0)
            $display("footprint_collision_check regression: pass");
        else
            $display("footprint_collision_check regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/fcc_pkg.sv
rtl/fcc_ram.sv
rtl/fcc_datapath.sv
rtl/fcc_ctrl.sv
rtl/footprint_collision_check.sv
test/footprint_collision_check_test.sv
